>>> hdl/ship_dip_stream_rrip_replacement_core_defines.svh
// Assertion macros used by the back end of the replacement core RTL.
`ifndef SHIP_DIP_STREAM_RRIP_REPLACEMENT_CORE_DEFINES_SVH
`define SHIP_DIP_STREAM_RRIP_REPLACEMENT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SDSR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdsr assertion failed");
`define SDSR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdsr assertion failed");
`else
`define SDSR_ASSERT_IMP(name, ante, cons)
`define SDSR_ASSERT_NXT(name, ante, cons)
`endif
`endif

>>> hdl/sdsr_pkg.sv
// Shared types, constants and helpers of the replacement core.
package sdsr_pkg;
  localparam int NUM_SETS_DEF       = 2048;
  localparam int NUM_WAYS_DEF       = 16;
  localparam int SIG_WIDTH_DEF      = 6;
  localparam int LEADER_COUNT_DEF   = 32;
  localparam int SELECTOR_WIDTH_DEF = 8;

  localparam int IN_SET_W  = 11;
  localparam int IN_WAY_W  = 4;
  localparam int ADDR_W    = 64;
  localparam int DRAW_W    = 5;
  localparam int OUT_WAY_W = 4;
  localparam int INS_W     = 2;
  localparam int CFG_W     = 32;
  localparam int KIND_W    = 2;

  localparam logic [CFG_W-1:0] DECAY_RESET = 32'd100000;
  localparam logic [1:0] RR_DISTANT = 2'd3;
  localparam logic [1:0] RR_NEAR    = 2'd0;
  localparam logic [1:0] CNT_STRONG = 2'd2;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [KIND_W-1:0] {LK_FOLLOW, LK_LIP, LK_BIP} leader_kind_t;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_EXEC1, B_EXEC2, B_SWEEP} back_state_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  function automatic logic [1:0] sat_inc2(input logic [1:0] v);
    return (v == 2'd3) ? v : v + 2'd1;
  endfunction

  function automatic logic [1:0] sat_dec2(input logic [1:0] v);
    return (v == 2'd0) ? v : v - 2'd1;
  endfunction
endpackage

>>> hdl/ship_dip_stream_rrip_replacement_core.sv
// Top level of the RRIP/DIP replacement core with stride and signature tracking.
// After reset the core runs a clearing pass over every row of its per-set
// memories and holds in_full high until it is done. Accesses then pass a
// two-stage front (set reduction, signature hash, leader classification) into a
// two-entry queue; the back takes one access at a time from one row read per
// set memory: a victim search or a hit update passes the EXEC1 state, a miss
// fill EXEC1 and EXEC2, and no new access starts before the read-modify-write
// of the set rows for the last one is done. When a miss fill completes a decay
// period, the back sweeps every row of the signature counter memory before the
// next access. A decay period write recomputes the count residue in the
// remainder unit, during which cfg_ready is low and no access starts. Results
// queue two deep on the output side.
module ship_dip_stream_rrip_replacement_core #(
  parameter int NUM_SETS       = sdsr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS       = sdsr_pkg::NUM_WAYS_DEF,
  parameter int SIG_WIDTH      = sdsr_pkg::SIG_WIDTH_DEF,
  parameter int LEADER_COUNT   = sdsr_pkg::LEADER_COUNT_DEF,
  parameter int SELECTOR_WIDTH = sdsr_pkg::SELECTOR_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_opcode,
  input  logic [sdsr_pkg::IN_SET_W-1:0]  in_set_index,
  input  logic [sdsr_pkg::IN_WAY_W-1:0]  in_way_index,
  input  logic [sdsr_pkg::ADDR_W-1:0]    in_phys_addr,
  input  logic [sdsr_pkg::ADDR_W-1:0]    in_prog_counter,
  input  logic                           in_was_hit,
  input  logic [sdsr_pkg::DRAW_W-1:0]    in_random_draw,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [sdsr_pkg::OUT_WAY_W-1:0] out_victim_way,
  output logic [sdsr_pkg::INS_W-1:0]     out_insert_position,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sdsr_pkg::CFG_W-1:0]     cfg_data
);
  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int ITEM_W = 1 + SET_W + WAY_W + sdsr_pkg::ADDR_W + SIG_WIDTH + 1
                          + sdsr_pkg::DRAW_W + sdsr_pkg::KIND_W;
  localparam int RES_W  = sdsr_pkg::OUT_WAY_W + sdsr_pkg::INS_W;

  logic                       f_full, q_push, q_full, q_pop, q_empty;
  logic [ITEM_W-1:0]          q_wdata, q_rdata;
  logic                       r_push, r_full;
  logic [RES_W-1:0]           r_wdata, r_rdata;
  logic                       cfg_we, mod_start;
  logic [sdsr_pkg::CFG_W-1:0] mod_dividend, mod_rem;
  sdsr_pkg::mod_stat_t        mod_stat;
  sdsr_pkg::back_stat_t       bstat;

  assign in_full   = f_full | bstat.clearing;
  assign cfg_ready = ~mod_stat.busy & ~mod_stat.done & ~bstat.clearing;
  assign cfg_we    = cfg_valid & cfg_ready;

  sdsr_front #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_WIDTH(SIG_WIDTH),
    .LEADER_COUNT(LEADER_COUNT)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .push(in_push & ~bstat.clearing), .full(f_full),
    .opcode(in_opcode), .set_index(in_set_index), .way_index(in_way_index),
    .phys_addr(in_phys_addr), .prog_counter(in_prog_counter),
    .was_hit(in_was_hit), .random_draw(in_random_draw),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  sdsr_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .full(q_full), .wdata(q_wdata),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  sdsr_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(mod_dividend),
    .divisor(cfg_data), .stat(mod_stat), .rem(mod_rem)
  );

  sdsr_back #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_WIDTH(SIG_WIDTH),
    .SELECTOR_WIDTH(SELECTOR_WIDTH)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_pop(q_pop), .q_data(q_rdata),
    .res_full(r_full), .res_push(r_push), .res_data(r_wdata),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .mod_start(mod_start), .mod_dividend(mod_dividend),
    .mod_stat(mod_stat), .mod_rem(mod_rem), .stat(bstat)
  );

  sdsr_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_results (
    .clk(clk), .rst_n(rst_n), .push(r_push), .full(r_full), .wdata(r_wdata),
    .pop(out_pop), .empty(out_empty), .rdata(r_rdata)
  );

  assign {out_victim_way, out_insert_position} = r_rdata;
endmodule

>>> hdl/sdsr_ram.sv
// Generic single write port RAM with registered read.
module sdsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/sdsr_fifo.sv
// Small flop-based FIFO used between front and back and for results.
module sdsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = data_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wp_r] <= wdata;
    end
  end
endmodule

>>> hdl/sdsr_front.sv
// Front end: accepts accesses, reduces set/way, hashes the signature, classifies the set.
module sdsr_front #(
  parameter int NUM_SETS     = sdsr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS     = sdsr_pkg::NUM_WAYS_DEF,
  parameter int SIG_WIDTH    = sdsr_pkg::SIG_WIDTH_DEF,
  parameter int LEADER_COUNT = sdsr_pkg::LEADER_COUNT_DEF,
  localparam int SET_W  = $clog2(NUM_SETS),
  localparam int WAY_W  = $clog2(NUM_WAYS),
  localparam int ITEM_W = 1 + SET_W + WAY_W + sdsr_pkg::ADDR_W + SIG_WIDTH + 1
                          + sdsr_pkg::DRAW_W + sdsr_pkg::KIND_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          opcode,
  input  logic [sdsr_pkg::IN_SET_W-1:0] set_index,
  input  logic [sdsr_pkg::IN_WAY_W-1:0] way_index,
  input  logic [sdsr_pkg::ADDR_W-1:0]   phys_addr,
  input  logic [sdsr_pkg::ADDR_W-1:0]   prog_counter,
  input  logic                          was_hit,
  input  logic [sdsr_pkg::DRAW_W-1:0]   random_draw,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [ITEM_W-1:0]             q_data
);
  // set_index % NUM_SETS via reciprocal multiply, one correction step
  localparam int SHIFT = 22;
  localparam int RECIP = ((1 << SHIFT) + NUM_SETS - 1) / NUM_SETS;
  localparam int PW    = sdsr_pkg::IN_SET_W + SHIFT;
  localparam int RW    = sdsr_pkg::IN_SET_W + SET_W + 2;
  localparam int LKW   = SET_W + 10;

  logic                          a_v_r, b_v_r;
  logic                          a_op_r, b_op_r, a_hit_r, b_hit_r;
  logic [sdsr_pkg::IN_SET_W-1:0] a_set_r, b_set_r, b_q_r;
  logic [sdsr_pkg::IN_WAY_W-1:0] a_way_r, b_way_r;
  logic [sdsr_pkg::ADDR_W-1:0]   a_addr_r, b_addr_r, a_pc_r, b_pc_r;
  logic [sdsr_pkg::DRAW_W-1:0]   a_draw_r, b_draw_r;
  logic                          a_free, b_free;
  logic [PW-1:0]                 a_prod;
  logic signed [RW-1:0]          b_qn, b_rem;
  logic [SET_W-1:0]              set_red;
  logic [WAY_W-1:0]              way_red;
  logic [SIG_WIDTH-1:0]          sig;
  sdsr_pkg::leader_kind_t        kind;

  assign b_free = ~b_v_r | ~q_full;
  assign a_free = ~a_v_r | b_free;
  assign full   = ~a_free;
  assign a_prod = PW'(a_set_r) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_r <= push;
      end
      if (b_free) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && push) begin
      a_op_r   <= opcode;
      a_set_r  <= set_index;
      a_way_r  <= way_index;
      a_addr_r <= phys_addr;
      a_pc_r   <= prog_counter;
      a_hit_r  <= was_hit;
      a_draw_r <= random_draw;
    end
    if (b_free && a_v_r) begin
      b_op_r   <= a_op_r;
      b_set_r  <= a_set_r;
      b_q_r    <= a_prod[PW-1:SHIFT];
      b_way_r  <= a_way_r;
      b_addr_r <= a_addr_r;
      b_pc_r   <= a_pc_r;
      b_hit_r  <= a_hit_r;
      b_draw_r <= a_draw_r;
    end
  end

  always_comb begin
    // quotient estimate may be one high; fix up a negative remainder
    b_qn  = RW'(b_q_r) * RW'(NUM_SETS);
    b_rem = RW'(b_set_r) - b_qn;
    if (b_rem < 0) begin
      b_rem = b_rem + RW'(NUM_SETS);
    end
    set_red = b_rem[SET_W-1:0];

    way_red = '0;
    for (int i = 0; i < (1 << sdsr_pkg::IN_WAY_W); i++) begin
      if (b_way_r == sdsr_pkg::IN_WAY_W'(i)) begin
        way_red = WAY_W'(i % NUM_WAYS);
      end
    end

    sig = b_pc_r[SIG_WIDTH-1:0] ^ b_pc_r[SIG_WIDTH+5:6] ^ SIG_WIDTH'({set_red, 2'b00});

    // BIP leaders win where both ranges overlap
    if (LKW'(set_red) + LKW'(LEADER_COUNT) >= LKW'(NUM_SETS)) begin
      kind = sdsr_pkg::LK_BIP;
    end else if (LKW'(set_red) < LKW'(LEADER_COUNT)) begin
      kind = sdsr_pkg::LK_LIP;
    end else begin
      kind = sdsr_pkg::LK_FOLLOW;
    end
  end

  assign q_push = b_v_r;
  assign q_data = {b_op_r, set_red, way_red, b_addr_r, sig, b_hit_r, b_draw_r, kind};
endmodule

>>> hdl/sdsr_mod.sv
// Restoring remainder unit: recomputes update count modulo a new decay period.
module sdsr_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sdsr_pkg::CFG_W-1:0] dividend,
  input  logic [sdsr_pkg::CFG_W-1:0] divisor,
  output sdsr_pkg::mod_stat_t        stat,
  output logic [sdsr_pkg::CFG_W-1:0] rem
);
  localparam int W   = sdsr_pkg::CFG_W;
  localparam int BCW = $clog2(W);

  logic           run_r, done_r;
  logic [BCW-1:0] bit_r;
  logic [W-1:0]   dv_r, dvs_r;
  logic [W:0]     rem_r, trial;

  assign trial = {rem_r[W-1:0], dv_r[W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && bit_r == BCW'(W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bit_r <= '0;
      dv_r  <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      bit_r <= bit_r + BCW'(1);
      dv_r  <= {dv_r[W-2:0], 1'b0};
      rem_r <= (trial >= {1'b0, dvs_r}) ? trial - {1'b0, dvs_r} : trial;
    end
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign rem       = rem_r[W-1:0];
endmodule

>>> hdl/sdsr_back.sv
// Back end: per-set state memories, victim aging, update, insertion policy, decay sweep.
`include "ship_dip_stream_rrip_replacement_core_defines.svh"
module sdsr_back #(
  parameter int NUM_SETS       = sdsr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS       = sdsr_pkg::NUM_WAYS_DEF,
  parameter int SIG_WIDTH      = sdsr_pkg::SIG_WIDTH_DEF,
  parameter int SELECTOR_WIDTH = sdsr_pkg::SELECTOR_WIDTH_DEF,
  localparam int SET_W  = $clog2(NUM_SETS),
  localparam int WAY_W  = $clog2(NUM_WAYS),
  localparam int ITEM_W = 1 + SET_W + WAY_W + sdsr_pkg::ADDR_W + SIG_WIDTH + 1
                          + sdsr_pkg::DRAW_W + sdsr_pkg::KIND_W,
  localparam int RES_W  = sdsr_pkg::OUT_WAY_W + sdsr_pkg::INS_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [ITEM_W-1:0]          q_data,
  input  logic                       res_full,
  output logic                       res_push,
  output logic [RES_W-1:0]           res_data,
  input  logic                       cfg_we,
  input  logic [sdsr_pkg::CFG_W-1:0] cfg_data,
  output logic                       mod_start,
  output logic [sdsr_pkg::CFG_W-1:0] mod_dividend,
  input  sdsr_pkg::mod_stat_t        mod_stat,
  input  logic [sdsr_pkg::CFG_W-1:0] mod_rem,
  output sdsr_pkg::back_stat_t       stat
);
  localparam int AW      = sdsr_pkg::ADDR_W;
  localparam int NSIG    = 1 << SIG_WIDTH;
  localparam int RR_W    = NUM_WAYS * 2;
  localparam int BS_W    = NUM_WAYS * SIG_WIDTH;
  localparam int RU_W    = NSIG * 2;
  localparam int ST_W    = 2 + 2 * AW;
  localparam int SET_LSB = WAY_W + AW + SIG_WIDTH + 1 + sdsr_pkg::DRAW_W + sdsr_pkg::KIND_W;
  localparam int CW      = sdsr_pkg::CFG_W;
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MID = SELECTOR_WIDTH'(1) << (SELECTOR_WIDTH - 1);
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MAX = '1;

  sdsr_pkg::back_state_t state_r, state_nxt;
  logic [ITEM_W-1:0]     item_r, item_nxt;
  logic [SET_W-1:0]      clr_r, clr_nxt, swa_r, swa_nxt;
  logic [SET_W:0]        sw_r, sw_nxt;
  logic                  swp_r, swp_nxt, strm_r, strm_nxt;
  logic [SELECTOR_WIDTH-1:0] sel_r, sel_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt, res_r, res_nxt, decay_r;

  logic                  it_op, it_hit;
  logic [SET_W-1:0]      it_set;
  logic [WAY_W-1:0]      it_way;
  logic [AW-1:0]         it_addr;
  logic [SIG_WIDTH-1:0]  it_sig, old_sig;
  logic [sdsr_pkg::DRAW_W-1:0] it_draw;
  logic [sdsr_pkg::KIND_W-1:0] it_kind_raw;
  sdsr_pkg::leader_kind_t      it_kind;

  logic [SET_W-1:0] raddr, waddr;
  logic rr_we, bs_we, ru_we, st_we;
  logic [RR_W-1:0] rr_rdata, rr_wdata;
  logic [BS_W-1:0] bs_rdata, bs_wdata;
  logic [RU_W-1:0] ru_rdata, ru_wdata;
  logic [ST_W-1:0] st_rdata, st_wdata;

  logic [1:0] rr_max, age, ins, st_cnt_new;
  logic [RR_W-1:0] rr_aged;
  logic [sdsr_pkg::OUT_WAY_W-1:0] vic;
  logic [AW-1:0] prev_addr, stride;
  logic hi_any, lo_any, stride_eq, upd, decay_hit, sig_strong;
  logic [CW-1:0] res_inc;

  assign {it_op, it_set, it_way, it_addr, it_sig, it_hit, it_draw, it_kind_raw} = item_r;
  assign it_kind = sdsr_pkg::leader_kind_t'(it_kind_raw);
  assign old_sig = bs_rdata[int'(it_way)*SIG_WIDTH +: SIG_WIDTH];

  sdsr_ram #(.WIDTH(RR_W), .DEPTH(NUM_SETS)) u_rr (
    .clk(clk), .we(rr_we), .waddr(waddr), .wdata(rr_wdata), .raddr(raddr), .rdata(rr_rdata));
  sdsr_ram #(.WIDTH(BS_W), .DEPTH(NUM_SETS)) u_bs (
    .clk(clk), .we(bs_we), .waddr(waddr), .wdata(bs_wdata), .raddr(raddr), .rdata(bs_rdata));
  sdsr_ram #(.WIDTH(RU_W), .DEPTH(NUM_SETS)) u_ru (
    .clk(clk), .we(ru_we), .waddr(waddr), .wdata(ru_wdata), .raddr(raddr), .rdata(ru_rdata));
  sdsr_ram #(.WIDTH(ST_W), .DEPTH(NUM_SETS)) u_st (
    .clk(clk), .we(st_we), .waddr(waddr), .wdata(st_wdata), .raddr(raddr), .rdata(st_rdata));

  // aging: add (distant - max) to every way, then pick the lowest distant way
  always_comb begin
    hi_any = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      hi_any = hi_any | rr_rdata[2*w+1];
    end
    lo_any = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      lo_any = lo_any | (rr_rdata[2*w] & (rr_rdata[2*w+1] == hi_any));
    end
    rr_max = {hi_any, lo_any};
    age    = sdsr_pkg::RR_DISTANT - rr_max;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rr_aged[2*w +: 2] = rr_rdata[2*w +: 2] + age;
    end
    vic = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rr_aged[2*w +: 2] == sdsr_pkg::RR_DISTANT) begin
        vic = sdsr_pkg::OUT_WAY_W'(w);
      end
    end
  end

  // stride tracking
  always_comb begin
    prev_addr = st_rdata[2*AW-1:AW];
    stride    = (prev_addr == '0) ? '0 : it_addr - prev_addr;
    stride_eq = (prev_addr != '0) && (stride == st_rdata[AW-1:0]) && (stride != '0);
    st_cnt_new = stride_eq ? sdsr_pkg::sat_inc2(st_rdata[ST_W-1 -: 2])
                           : sdsr_pkg::sat_dec2(st_rdata[ST_W-1 -: 2]);
  end

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    clr_nxt    = clr_r;
    sw_nxt     = sw_r;
    swa_nxt    = swa_r;
    swp_nxt    = swp_r;
    strm_nxt   = strm_r;
    sel_nxt    = sel_r;
    q_pop      = 1'b0;
    res_push   = 1'b0;
    res_data   = '0;
    raddr      = it_set;
    waddr      = it_set;
    rr_we      = 1'b0;
    bs_we      = 1'b0;
    ru_we      = 1'b0;
    st_we      = 1'b0;
    rr_wdata   = rr_rdata;
    bs_wdata   = bs_rdata;
    ru_wdata   = ru_rdata;
    st_wdata   = {st_cnt_new, it_addr, stride};
    upd        = 1'b0;
    decay_hit  = 1'b0;
    sig_strong = 1'b0;
    ins        = sdsr_pkg::RR_DISTANT;

    case (state_r)
      sdsr_pkg::B_CLEAR: begin
        waddr    = clr_r;
        rr_we    = 1'b1;
        bs_we    = 1'b1;
        ru_we    = 1'b1;
        st_we    = 1'b1;
        rr_wdata = {NUM_WAYS{sdsr_pkg::RR_DISTANT}};
        bs_wdata = '0;
        ru_wdata = '0;
        st_wdata = '0;
        clr_nxt  = clr_r + SET_W'(1);
        if (clr_r == SET_W'(NUM_SETS - 1)) begin
          state_nxt = sdsr_pkg::B_IDLE;
        end
      end
      sdsr_pkg::B_IDLE: begin
        raddr = q_data[SET_LSB +: SET_W];
        // no start while a period write captures the update count
        if (!q_empty && !res_full && !mod_stat.busy && !mod_stat.done && !cfg_we) begin
          q_pop     = 1'b1;
          item_nxt  = q_data;
          state_nxt = sdsr_pkg::B_EXEC1;
        end
      end
      sdsr_pkg::B_EXEC1: begin
        if (it_op == sdsr_pkg::OP_VICTIM) begin
          rr_we     = 1'b1;
          rr_wdata  = rr_aged;
          res_push  = 1'b1;
          res_data  = {vic, sdsr_pkg::INS_W'(0)};
          state_nxt = sdsr_pkg::B_IDLE;
        end else if (it_hit) begin
          ru_we = 1'b1;
          ru_wdata[int'(old_sig)*2 +: 2] = sdsr_pkg::sat_inc2(ru_rdata[int'(old_sig)*2 +: 2]);
          rr_we = 1'b1;
          rr_wdata[int'(it_way)*2 +: 2] = sdsr_pkg::RR_NEAR;
          res_push  = 1'b1;
          res_data  = '0;
          upd       = 1'b1;
          state_nxt = sdsr_pkg::B_IDLE;
        end else begin
          st_we     = 1'b1;
          strm_nxt  = (st_cnt_new >= 2'd2);
          state_nxt = sdsr_pkg::B_EXEC2;
        end
      end
      sdsr_pkg::B_EXEC2: begin
        // old signature decays first; the new one is checked after that
        ru_wdata[int'(old_sig)*2 +: 2] = sdsr_pkg::sat_dec2(ru_rdata[int'(old_sig)*2 +: 2]);
        sig_strong = (ru_wdata[int'(it_sig)*2 +: 2] >= sdsr_pkg::CNT_STRONG);
        if (strm_r || it_kind == sdsr_pkg::LK_LIP) begin
          ins = sdsr_pkg::RR_DISTANT;
        end else if (it_kind == sdsr_pkg::LK_BIP || sel_r < SEL_MID) begin
          ins = (it_draw == '0) ? sdsr_pkg::RR_NEAR : sdsr_pkg::RR_DISTANT;
        end
        if (!strm_r && sig_strong) begin
          ins = sdsr_pkg::RR_NEAR;
        end
        ru_we = 1'b1;
        rr_we = 1'b1;
        bs_we = 1'b1;
        rr_wdata[int'(it_way)*2 +: 2] = ins;
        bs_wdata[int'(it_way)*SIG_WIDTH +: SIG_WIDTH] = it_sig;
        if (it_kind == sdsr_pkg::LK_LIP && sel_r != '0) begin
          sel_nxt = sel_r - SELECTOR_WIDTH'(1);
        end else if (it_kind == sdsr_pkg::LK_BIP && sel_r != SEL_MAX) begin
          sel_nxt = sel_r + SELECTOR_WIDTH'(1);
        end
        res_push  = 1'b1;
        res_data  = {sdsr_pkg::OUT_WAY_W'(0), ins};
        upd       = 1'b1;
        decay_hit = (decay_r != '0) && (res_nxt == '0);
        if (decay_hit) begin
          sw_nxt    = '0;
          swp_nxt   = 1'b0;
          state_nxt = sdsr_pkg::B_SWEEP;
        end else begin
          state_nxt = sdsr_pkg::B_IDLE;
        end
      end
      sdsr_pkg::B_SWEEP: begin
        // read row n while writing back row n-1
        waddr = swa_r;
        ru_we = swp_r;
        for (int e = 0; e < NSIG; e++) begin
          ru_wdata[2*e +: 2] = sdsr_pkg::sat_dec2(ru_rdata[2*e +: 2]);
        end
        raddr = sw_r[SET_W-1:0];
        if (sw_r < (SET_W+1)'(NUM_SETS)) begin
          swa_nxt = sw_r[SET_W-1:0];
          swp_nxt = 1'b1;
          sw_nxt  = sw_r + (SET_W+1)'(1);
        end else begin
          swp_nxt   = 1'b0;
          state_nxt = sdsr_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = sdsr_pkg::B_IDLE;
      end
    endcase
  end

  // update count and its residue modulo the decay period
  always_comb begin
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    res_inc = res_r + CW'(1);
    if (upd) begin
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_nxt == '0 || res_inc == decay_r) begin
        res_nxt = '0;
      end else begin
        res_nxt = res_inc;
      end
    end
    if (mod_stat.done) begin
      res_nxt = mod_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdsr_pkg::B_CLEAR;
      clr_r   <= '0;
      sw_r    <= '0;
      swp_r   <= 1'b0;
      sel_r   <= SEL_MID;
      cnt_r   <= '0;
      res_r   <= '0;
      decay_r <= sdsr_pkg::DECAY_RESET;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      sw_r    <= sw_nxt;
      swp_r   <= swp_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
      res_r   <= res_nxt;
      if (cfg_we) begin
        decay_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    swa_r  <= swa_nxt;
    strm_r <= strm_nxt;
  end

  assign mod_start     = cfg_we;
  assign mod_dividend  = cnt_r;
  assign stat.clearing = (state_r == sdsr_pkg::B_CLEAR);
  assign stat.idle     = (state_r == sdsr_pkg::B_IDLE);

  `SDSR_ASSERT_IMP(a_no_result_in_clear, state_r == sdsr_pkg::B_CLEAR, !res_push)
  `SDSR_ASSERT_IMP(a_result_has_room, res_push, !res_full)
  `SDSR_ASSERT_NXT(a_pop_starts_exec, q_pop, state_r == sdsr_pkg::B_EXEC1)
  `SDSR_ASSERT_NXT(a_decay_starts_sweep, decay_hit, state_r == sdsr_pkg::B_SWEEP)
endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the RRIP/DIP replacement core with stride and signature tracking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS = sdsr_pkg::NUM_SETS_DEF;
  localparam int WAYS = sdsr_pkg::NUM_WAYS_DEF;
  localparam int SIGS = 1 << sdsr_pkg::SIG_WIDTH_DEF;
  localparam int LEADERS = sdsr_pkg::LEADER_COUNT_DEF;
  localparam logic [7:0] SEL_MID = 8'd128;
  localparam logic [7:0] SEL_MAX = 8'd255;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic              op;
    logic [10:0]       set_idx;
    logic [3:0]        way;
    logic [63:0]       addr;
    logic [63:0]       pc;
    logic              hit;
    logic [4:0]        draw;
  } access_t;

  typedef struct {
    logic [3:0] victim;
    logic [1:0] ins;
  } decision_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_opcode = 1'b0;
  logic [10:0] in_set_index = '0;
  logic [3:0] in_way_index = '0;
  logic [63:0] in_phys_addr = '0;
  logic [63:0] in_prog_counter = '0;
  logic in_was_hit = 1'b0;
  logic [4:0] in_random_draw = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [3:0] out_victim_way;
  logic [1:0] out_insert_position;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  ship_dip_stream_rrip_replacement_core DUT (.*);

  // predictor state
  logic [1:0]  rrv_tbl   [SETS][WAYS];
  logic [5:0]  bsig_tbl  [SETS][WAYS];
  logic [1:0]  reuse_tbl [SETS][SIGS];
  logic [1:0]  stream_tbl[SETS];
  logic [63:0] prev_addr_tbl[SETS];
  logic [63:0] last_stride[SETS];
  logic [7:0]  psel;
  logic [31:0] access_count;
  logic [31:0] decay_len;

  decision_t expected_q[$];
  logic [3:0] last_victim;
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void predictor_reset();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        rrv_tbl[s][w] = sdsr_pkg::RR_DISTANT;
        bsig_tbl[s][w] = '0;
      end
      for (int g = 0; g < SIGS; g++) reuse_tbl[s][g] = '0;
      stream_tbl[s] = '0;
      prev_addr_tbl[s] = '0;
      last_stride[s] = '0;
    end
    psel = SEL_MID;
    access_count = '0;
    decay_len = sdsr_pkg::DECAY_RESET;
  endfunction

  function automatic sdsr_pkg::leader_kind_t kind_of(logic [10:0] s);
    if (int'(s) + LEADERS >= SETS) return sdsr_pkg::LK_BIP;
    if (int'(s) < LEADERS) return sdsr_pkg::LK_LIP;
    return sdsr_pkg::LK_FOLLOW;
  endfunction

  function automatic logic [3:0] age_and_pick(logic [10:0] s);
    logic [1:0] top;
    top = '0;
    for (int w = 0; w < WAYS; w++) if (rrv_tbl[s][w] > top) top = rrv_tbl[s][w];
    if (top < sdsr_pkg::RR_DISTANT)
      for (int w = 0; w < WAYS; w++)
        rrv_tbl[s][w] = rrv_tbl[s][w] + (sdsr_pkg::RR_DISTANT - top);
    for (int w = 0; w < WAYS; w++) if (rrv_tbl[s][w] == sdsr_pkg::RR_DISTANT) return 4'(w);
    return '0;
  endfunction

  function automatic logic [1:0] fill_or_promote(access_t a);
    logic [10:0] s;
    logic [63:0] stride;
    logic [5:0] sig;
    logic streaming;
    sdsr_pkg::leader_kind_t k;
    logic [1:0] ins;
    s = a.set_idx;
    access_count = access_count + 32'd1;
    if (a.hit) begin
      if (reuse_tbl[s][bsig_tbl[s][a.way]] != 2'd3)
        reuse_tbl[s][bsig_tbl[s][a.way]] += 2'd1;
      rrv_tbl[s][a.way] = sdsr_pkg::RR_NEAR;
      return '0;
    end
    stride = (prev_addr_tbl[s] == 0) ? 64'd0 : a.addr - prev_addr_tbl[s];
    if (prev_addr_tbl[s] != 0 && stride == last_stride[s] && stride != 0) begin
      if (stream_tbl[s] != 2'd3) stream_tbl[s] += 2'd1;
    end else if (stream_tbl[s] != 0) begin
      stream_tbl[s] -= 2'd1;
    end
    last_stride[s] = stride;
    prev_addr_tbl[s] = a.addr;
    sig = a.pc[5:0] ^ a.pc[11:6] ^ {s[3:0], 2'b00};
    if (reuse_tbl[s][bsig_tbl[s][a.way]] != 0) reuse_tbl[s][bsig_tbl[s][a.way]] -= 2'd1;
    streaming = stream_tbl[s] >= 2'd2;
    k = kind_of(s);
    if (streaming || k == sdsr_pkg::LK_LIP) ins = sdsr_pkg::RR_DISTANT;
    else if (k == sdsr_pkg::LK_BIP || psel < SEL_MID)
      ins = (a.draw == 0) ? sdsr_pkg::RR_NEAR : sdsr_pkg::RR_DISTANT;
    else ins = sdsr_pkg::RR_DISTANT;
    if (!streaming && reuse_tbl[s][sig] >= sdsr_pkg::CNT_STRONG) ins = sdsr_pkg::RR_NEAR;
    rrv_tbl[s][a.way] = ins;
    bsig_tbl[s][a.way] = sig;
    if (k == sdsr_pkg::LK_LIP && psel != 0) psel -= 8'd1;
    else if (k == sdsr_pkg::LK_BIP && psel != SEL_MAX) psel += 8'd1;
    if (decay_len != 0 && access_count % decay_len == 0)
      for (int x = 0; x < SETS; x++)
        for (int g = 0; g < SIGS; g++)
          if (reuse_tbl[x][g] != 0) reuse_tbl[x][g] -= 2'd1;
    return ins;
  endfunction

  function automatic void predict(access_t a);
    decision_t d;
    if (a.op == sdsr_pkg::OP_VICTIM) begin
      d.victim = age_and_pick(a.set_idx);
      d.ins = '0;
      last_victim = d.victim;
    end else begin
      d.victim = '0;
      d.ins = fill_or_promote(a);
    end
    expected_q.push_back(d);
  endfunction

  task automatic send(access_t a);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode <= a.op;
    in_set_index <= a.set_idx;
    in_way_index <= a.way;
    in_phys_addr <= a.addr;
    in_prog_counter <= a.pc;
    in_was_hit <= a.hit;
    in_random_draw <= a.draw;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    predict(a);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_decay(logic [31:0] v);
    drain();
    repeat (40) @(posedge clk);  // a completed fill may still be sweeping
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    decay_len = v;
  endtask

  function automatic access_t mk(logic op, logic [10:0] s, logic [3:0] w, logic [63:0] addr,
                                 logic [63:0] pc, logic hit, logic [4:0] draw);
    access_t a;
    a.op = op; a.set_idx = s; a.way = w; a.addr = addr; a.pc = pc; a.hit = hit; a.draw = draw;
    return a;
  endfunction

  function automatic logic [10:0] pick_set();
    case ($urandom_range(0, 3))
      0: return 11'($urandom_range(0, LEADERS - 1));
      1: return 11'($urandom_range(SETS - LEADERS, SETS - 1));
      2: return 11'($urandom_range(100, 107));
      default: return 11'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_pc();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return 64'h4000 + 64'($urandom_range(0, 5) * 4);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // victim search followed by the fill of the chosen way
  task automatic victim_then_fill(logic [10:0] s, logic [63:0] addr, logic [63:0] pc);
    send(mk(sdsr_pkg::OP_VICTIM, s, 4'($urandom), rnd64(), rnd64(), 1'($urandom),
            5'($urandom)));
    send(mk(sdsr_pkg::OP_UPDATE, s, last_victim, addr, pc, 1'b0, 5'($urandom_range(0, 3))));
  endtask

  task automatic run_mix(int n);
    logic [10:0] s;
    logic [63:0] base, step;
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 49) == 0) calm = ~calm;
      s = pick_set();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          victim_then_fill(s, rnd64(), pick_pc());
          k += 2;
        end
        3, 4: begin
          send(mk(sdsr_pkg::OP_UPDATE, s, 4'($urandom), rnd64(), pick_pc(), 1'b1,
                  5'($urandom)));
          k++;
        end
        5, 6: begin
          base = rnd64();
          step = ($urandom_range(0, 1) != 0) ? 64'd64 : 64'(-128);
          for (int i = 0; i < 5; i++) victim_then_fill(s, base + step * i, pick_pc());
          k += 10;
        end
        default: begin
          send(mk(1'($urandom), 11'($urandom), 4'($urandom), rnd64(), rnd64(),
                  1'($urandom), 5'($urandom)));
          k++;
        end
      endcase
    end
  endtask

  task automatic test_directed();
    set_decay(sdsr_pkg::DECAY_RESET);
    send(mk(sdsr_pkg::OP_VICTIM, 11'd0, 4'd0, 64'd0, 64'd0, 1'b0, 5'd0));
    // first access, LIP
    send(mk(sdsr_pkg::OP_UPDATE, 11'd0, 4'd15, 64'd0, 64'd0, 1'b0, 5'd0));
    // BIP near, then BIP distant
    send(mk(sdsr_pkg::OP_UPDATE, 11'd2047, 4'd3, '1, '1, 1'b0, 5'd0));
    send(mk(sdsr_pkg::OP_UPDATE, 11'd2047, 4'd4, 64'd1, '1, 1'b0, 5'd31));
    send(mk(sdsr_pkg::OP_VICTIM, 11'd2047, 4'd15, '1, '1, 1'b1, 5'd31));
    // hits raise reuse
    send(mk(sdsr_pkg::OP_UPDATE, 11'd2047, 4'd3, '1, '1, 1'b1, 5'd31));
    send(mk(sdsr_pkg::OP_UPDATE, 11'd2047, 4'd3, '1, '1, 1'b1, 5'd31));
    // strong signature
    send(mk(sdsr_pkg::OP_UPDATE, 11'd2047, 4'd5, 64'd77, '1, 1'b0, 5'd31));
    // follower
    send(mk(sdsr_pkg::OP_UPDATE, 11'd500, 4'd1, 64'h1000, 64'h40, 1'b0, 5'd0));
    // streaming set
    for (int i = 1; i < 6; i++)
      send(mk(sdsr_pkg::OP_UPDATE, 11'd500, 4'(i), 64'h1000 + 64'(i * 64), 64'h40, 1'b0,
              5'd0));
    send(mk(sdsr_pkg::OP_VICTIM, 11'd500, 4'd0, 64'd0, 64'd0, 1'b0, 5'd0));
    send(mk(sdsr_pkg::OP_UPDATE, 11'd31, 4'd9, 64'h8000_0000_0000_0000, 64'h0, 1'b0, 5'd1));
    send(mk(sdsr_pkg::OP_UPDATE, 11'd2016, 4'd2, 64'h5, 64'h3F, 1'b0, 5'd0));
  endtask

  task automatic test_fast_decay();
    set_decay(32'd1);
    for (int i = 0; i < 4; i++) victim_then_fill(pick_set(), rnd64(), pick_pc());
    set_decay(32'd3);
    run_mix(60);
  endtask

  task automatic test_decay_extremes();
    set_decay('1);
    run_mix(60);
    set_decay(32'd0);
    run_mix(60);
  endtask

  task automatic test_random();
    set_decay(sdsr_pkg::DECAY_RESET);
    run_mix(400);
    drain();  // sender holds off until all results are back
    run_mix(400);
  endtask

  // result side: random stalls, checks every transfer
  initial begin
    decision_t d;
    int gap;
    @(posedge rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: victim_way=%0d insert_position=%0d",
               out_victim_way, out_insert_position);
        errors++;
      end else begin
        d = expected_q.pop_front();
        if (out_victim_way !== d.victim) begin
          $error("victim_way expected %0d actual %0d", d.victim, out_victim_way);
          errors++;
        end
        if (out_insert_position !== d.ins) begin
          $error("insert_position expected %0d actual %0d", d.ins, out_insert_position);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    predictor_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fast_decay();
    test_decay_extremes();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

>>> ship_dip_stream_rrip_replacement_core.f
+incdir+hdl
hdl/sdsr_pkg.sv
hdl/sdsr_ram.sv
hdl/sdsr_fifo.sv
hdl/sdsr_front.sv
hdl/sdsr_mod.sv
hdl/sdsr_back.sv
hdl/ship_dip_stream_rrip_replacement_core.sv
dv/tb_top.sv
